>>> hdl/fsnp_pkg.sv
// Shared types, constants and character helpers for the FAT short-name parser.
// No dependencies.
package fsnp_pkg;

  localparam int LengthLimit = 255;
  localparam int CountW      = $clog2(LengthLimit + 1);
  localparam int CntExtW     = (CountW > 8) ? CountW : 8;

  localparam int BaseLen = 8;
  localparam int ExtLen  = 3;

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] LenMax  = 8'hFF;

  localparam logic [63:0] PadBase = {BaseLen{ChSpace}};
  localparam logic [23:0] PadExt  = {ExtLen{ChSpace}};

  typedef enum logic [1:0] {
    STATUS_VALID   = 2'd0,
    STATUS_EMPTY   = 2'd1,
    STATUS_INVALID = 2'd2
  } status_e;

  // Classification of one path byte.
  typedef struct packed {
    logic       is_term;
    logic       is_nul;
    logic       is_dot;
    logic       is_reserved;
    logic       is_alnum;
    logic [7:0] upper;
  } char_class_t;

  // Byte held in the input register.
  typedef struct packed {
    logic       vld;
    logic [7:0] data;
  } stage_t;

endpackage

>>> hdl/fsnp_intf.sv
// Handshake channels of the FAT short-name parser: path bytes in, names out.
// Depends on fsnp_pkg.
interface fsnp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] path_byte;

  modport source (output valid, output path_byte, input ready);
  modport sink   (input valid, input path_byte, output ready);
endinterface

interface fsnp_name_if
  import fsnp_pkg::*;
;
  logic        valid;
  logic        ready;
  logic [63:0] base_name;
  logic [23:0] extension;
  status_e     status;
  logic [7:0]  component_length;
  logic        path_ended;

  modport source (output valid, output base_name, output extension, output status,
                  output component_length, output path_ended, input ready);
  modport sink   (input valid, input base_name, input extension, input status,
                  input component_length, input path_ended, output ready);
endinterface

>>> hdl/fsnp_char_class.sv
// Byte classifier: terminator, dot, reserved punctuation, alphanumeric, uppercase.
// Depends on fsnp_pkg.
module fsnp_char_class
  import fsnp_pkg::*;
(
  input  logic [7:0]  byte_i,
  output char_class_t class_o
);

  always_comb begin
    class_o.is_nul      = (byte_i == ChNul);
    class_o.is_term     = (byte_i == ChNul) || (byte_i == ChSlash);
    class_o.is_dot      = (byte_i == ChDot);
    class_o.is_reserved = (byte_i inside {8'h22, 8'h2A, [8'h2B:8'h2F], [8'h3A:8'h3F],
                                          [8'h5B:8'h5D], [8'h7C:8'h7E]});
    class_o.is_alnum    = (byte_i inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]});
    class_o.upper       = (byte_i inside {[8'h61:8'h7A]}) ? (byte_i - 8'h20) : byte_i;
  end

endmodule

>>> hdl/fsnp_accum.sv
// Component accumulator: per-byte state update and the registered name result.
// Depends on fsnp_pkg, fsnp_intf and fsnp_char_class.
module fsnp_accum
  import fsnp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  stage_t           stage_i,
  output logic             adv_o,
  fsnp_name_if.source      name_o
);

  char_class_t cls;

  logic [63:0]       base_q, base_d;
  logic [23:0]       ext_q, ext_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic              dot_q, dot_d;
  logic [1:0]        ecnt_q, ecnt_d;
  logic              bad_q, bad_d;
  logic              lead_q, lead_d;
  logic              dd_q, dd_d;

  logic              out_vld_q, out_vld_d;
  logic [63:0]       r_base_q, r_base_d;
  logic [23:0]       r_ext_q, r_ext_d;
  status_e           r_stat_q, r_stat_d;
  logic [7:0]        r_len_q, r_len_d;
  logic              r_end_q, r_end_d;

  logic              out_free;
  logic              take;
  logic [CntExtW-1:0] cnt_ext;

  fsnp_char_class u_class (
    .byte_i  (stage_i.data),
    .class_o (cls)
  );

  assign out_free = !out_vld_q || name_o.ready;
  assign adv_o    = !cls.is_term || out_free;
  assign take     = stage_i.vld && adv_o;
  assign cnt_ext  = CntExtW'(cnt_q);

  always_comb begin
    base_d    = base_q;
    ext_d     = ext_q;
    cnt_d     = cnt_q;
    dot_d     = dot_q;
    ecnt_d    = ecnt_q;
    bad_d     = bad_q;
    lead_d    = lead_q;
    dd_d      = dd_q;
    r_base_d  = r_base_q;
    r_ext_d   = r_ext_q;
    r_stat_d  = r_stat_q;
    r_len_d   = r_len_q;
    r_end_d   = r_end_q;
    out_vld_d = out_vld_q && !name_o.ready;

    if (take && cls.is_term) begin
      r_base_d = PadBase;
      r_ext_d  = PadExt;
      if (cnt_q == '0) begin
        r_stat_d = STATUS_EMPTY;
      end else if (lead_q) begin
        if (cnt_q == CountW'(1)) begin
          r_stat_d = STATUS_VALID;
          r_base_d = {PadBase[63:8], ChDot};
        end else if (cnt_q == CountW'(2) && dd_q) begin
          r_stat_d = STATUS_VALID;
          r_base_d = {PadBase[63:16], ChDot, ChDot};
        end else begin
          r_stat_d = STATUS_INVALID;
        end
      end else if (bad_q) begin
        r_stat_d = STATUS_INVALID;
      end else begin
        r_stat_d = STATUS_VALID;
        r_base_d = base_q;
        r_ext_d  = ext_q;
      end
      r_len_d   = (cnt_ext > CntExtW'(255)) ? LenMax : cnt_ext[7:0];
      r_end_d   = cls.is_nul;
      out_vld_d = 1'b1;
      // component done: back to the cleared state
      base_d = PadBase;
      ext_d  = PadExt;
      cnt_d  = '0;
      dot_d  = 1'b0;
      ecnt_d = '0;
      bad_d  = 1'b0;
      lead_d = 1'b0;
      dd_d   = 1'b0;
    end else if (take) begin
      if (cnt_q == '0 && cls.is_dot) lead_d = 1'b1;
      if (cnt_q == CountW'(1) && lead_q && cls.is_dot) dd_d = 1'b1;

      if (!dot_q) begin
        if (cls.is_dot) begin
          dot_d = 1'b1;
        end else if (cnt_q < CountW'(BaseLen)) begin
          if (cls.is_reserved) begin
            bad_d = 1'b1;
          end else begin
            for (int i = 0; i < BaseLen; i++) begin
              if (cnt_q[2:0] == 3'(i)) base_d[i*8 +: 8] = cls.upper;
            end
          end
        end
      end else if (ecnt_q < 2'(ExtLen)) begin
        if (cls.is_alnum) begin
          for (int i = 0; i < ExtLen; i++) begin
            if (ecnt_q == 2'(i)) ext_d[i*8 +: 8] = cls.upper;
          end
        end else begin
          bad_d = 1'b1;
        end
        ecnt_d = ecnt_q + 2'd1;
      end

      if (cnt_q < CountW'(LengthLimit)) cnt_d = cnt_q + CountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q    <= PadBase;
      ext_q     <= PadExt;
      cnt_q     <= '0;
      dot_q     <= 1'b0;
      ecnt_q    <= '0;
      bad_q     <= 1'b0;
      lead_q    <= 1'b0;
      dd_q      <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      base_q    <= base_d;
      ext_q     <= ext_d;
      cnt_q     <= cnt_d;
      dot_q     <= dot_d;
      ecnt_q    <= ecnt_d;
      bad_q     <= bad_d;
      lead_q    <= lead_d;
      dd_q      <= dd_d;
      out_vld_q <= out_vld_d;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    r_base_q <= r_base_d;
    r_ext_q  <= r_ext_d;
    r_stat_q <= r_stat_d;
    r_len_q  <= r_len_d;
    r_end_q  <= r_end_d;
  end

  assign name_o.valid            = out_vld_q;
  assign name_o.base_name        = r_base_q;
  assign name_o.extension        = r_ext_q;
  assign name_o.status           = r_stat_q;
  assign name_o.component_length = r_len_q;
  assign name_o.path_ended       = r_end_q;

endmodule

>>> hdl/fat_short_name_parser_unit.sv
// Top level of the FAT 8.3 short-name parser: input register and accumulator.
// Depends on fsnp_pkg, fsnp_intf and fsnp_accum.
//
// Path bytes stream in one per clock; each slash (0x2F) or NUL (0x00) closes a
// component and yields one transaction on name_o with the space-padded 8.3 name,
// a status (valid, empty, invalid), the component length saturated at 255 and
// whether the path ended. Other bytes yield nothing. Throughput is one byte per
// cycle: the input register feeds the accumulator, whose per-byte update is a
// single shallow classification step. A terminator accepted on path_i goes to the
// input register, and its result is registered once the result register is free.
// Only a terminator waiting behind an unconsumed result stalls the input;
// ordinary bytes keep flowing while a result waits.
module fat_short_name_parser_unit
  import fsnp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  fsnp_byte_if.sink   path_i,
  fsnp_name_if.source name_o
);

  stage_t stage_q, stage_d;
  logic   adv;

  // input register takes a byte when empty or when its byte moves on
  assign path_i.ready = !stage_q.vld || adv;

  always_comb begin
    stage_d = stage_q;
    if (path_i.ready) begin
      stage_d.vld  = path_i.valid;
      stage_d.data = path_i.path_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else begin
      stage_q <= stage_d;
    end
  end

  fsnp_accum u_accum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .stage_i (stage_q),
    .adv_o   (adv),
    .name_o  (name_o)
  );

endmodule

>>> bench/fsnp_name_checker.sv
// Checker for the FAT short-name parser: watches both channels, predicts each name.
// Depends on fsnp_pkg and the channel interfaces in fsnp_intf.
module fsnp_name_checker
  import fsnp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  fsnp_byte_if path_i,
  fsnp_name_if name_i,
  output int   mismatch_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [63:0] base_name;
    logic [23:0] extension;
    status_e     status;
    logic [7:0]  component_length;
    logic        path_ended;
  } short_name_t;

  // Component being assembled
  logic [63:0]       base_acc;
  logic [23:0]       ext_acc;
  logic [CountW-1:0] char_cnt;
  logic              dot_seen;
  logic [1:0]        ext_cnt;
  logic              bad_char;
  logic              lead_dot;
  logic              dot_dot;

  short_name_t expected_names[$];
  int          mismatches;

  function automatic logic is_reserved_char(input logic [7:0] c);
    return c == 8'h22 || (c >= 8'h2A && c <= 8'h2F) || (c >= 8'h3A && c <= 8'h3F) ||
           (c >= 8'h5B && c <= 8'h5D) || (c >= 8'h7C && c <= 8'h7E);
  endfunction

  function automatic logic is_alnum_char(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic [7:0] upcase(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
  endfunction

  task clear_component();
    base_acc = PadBase;
    ext_acc  = PadExt;
    char_cnt = '0;
    dot_seen = 1'b0;
    ext_cnt  = '0;
    bad_char = 1'b0;
    lead_dot = 1'b0;
    dot_dot  = 1'b0;
  endtask

  task automatic parse_path_byte(input logic [7:0] ch);
    short_name_t nm;
    if (ch == ChNul || ch == ChSlash) begin
      nm.base_name        = PadBase;
      nm.extension        = PadExt;
      nm.component_length = (char_cnt > LenMax) ? LenMax : char_cnt[7:0];
      nm.path_ended       = (ch == ChNul);
      if (char_cnt == 0) begin
        nm.status = STATUS_EMPTY;
      end else if (lead_dot) begin
        // only "." and ".." may start with a dot
        if (char_cnt == 1) begin
          nm.status         = STATUS_VALID;
          nm.base_name[7:0] = ChDot;
        end else if (char_cnt == 2 && dot_dot) begin
          nm.status          = STATUS_VALID;
          nm.base_name[15:0] = {ChDot, ChDot};
        end else begin
          nm.status = STATUS_INVALID;
        end
      end else if (bad_char) begin
        nm.status = STATUS_INVALID;
      end else begin
        nm.status    = STATUS_VALID;
        nm.base_name = base_acc;
        nm.extension = ext_acc;
      end
      expected_names.push_back(nm);
      clear_component();
    end else begin
      if (char_cnt == 0 && ch == ChDot) lead_dot = 1'b1;
      if (char_cnt == 1 && lead_dot && ch == ChDot) dot_dot = 1'b1;
      if (!dot_seen) begin
        if (ch == ChDot) begin
          dot_seen = 1'b1;
        end else if (char_cnt < BaseLen) begin
          if (is_reserved_char(ch)) bad_char = 1'b1;
          else base_acc[8*char_cnt[2:0] +: 8] = upcase(ch);
        end
      end else if (ext_cnt < ExtLen) begin
        if (is_alnum_char(ch)) ext_acc[8*ext_cnt +: 8] = upcase(ch);
        else bad_char = 1'b1;
        ext_cnt = ext_cnt + 2'd1;
      end
      if (char_cnt < LengthLimit) char_cnt = char_cnt + 1'b1;
    end
  endtask

  task automatic check_name();
    short_name_t want;
    if (expected_names.size() == 0) begin
      $error("name transaction with none expected: base_name %h status %0d",
             name_i.base_name, name_i.status);
      mismatches++;
    end else begin
      want = expected_names.pop_front();
      if (name_i.base_name !== want.base_name) begin
        $error("base_name: expected %h, got %h", want.base_name, name_i.base_name);
        mismatches++;
      end
      if (name_i.extension !== want.extension) begin
        $error("extension: expected %h, got %h", want.extension, name_i.extension);
        mismatches++;
      end
      if (name_i.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, name_i.status);
        mismatches++;
      end
      if (name_i.component_length !== want.component_length) begin
        $error("component_length: expected %0d, got %0d", want.component_length,
               name_i.component_length);
        mismatches++;
      end
      if (name_i.path_ended !== want.path_ended) begin
        $error("path_ended: expected %b, got %b", want.path_ended, name_i.path_ended);
        mismatches++;
      end
    end
  endtask

  // Sampled at the edge: the bench drives with NBAs, so these are pre-edge values
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_component();
      expected_names.delete();
      mismatches = 0;
      mismatch_o <= 0;
      pending_o  <= 0;
    end else begin
      if (path_i.valid === 1'b1 && path_i.ready === 1'b1) parse_path_byte(path_i.path_byte);
      if (name_i.valid === 1'b1 && name_i.ready === 1'b1) check_name();
      mismatch_o <= mismatches;
      pending_o  <= expected_names.size();
    end
  end

endmodule

>>> bench/fat_short_name_parser_unit_tb.sv
// Top of the FAT short-name parser bench: clock, reset, path stimulus, name sink.
// Depends on fsnp_pkg, fsnp_intf, fsnp_name_checker and the parser RTL.
module fat_short_name_parser_unit_tb;
  import fsnp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i;
  logic rst_ni;

  fsnp_byte_if path_if ();
  fsnp_name_if name_if ();

  int fail_count;
  int names_pending;

  // Traffic shaping: sender idle and receiver stall odds, percent per cycle
  int   idle_pct  = 0;
  int   stall_pct = 0;
  logic hold_off  = 1'b0;   // receiver held off by the back-pressure process
  logic hold_go   = 1'b0;   // kicks off the back-pressure process
  int   bytes_sent = 0;

  fat_short_name_parser_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .path_i (path_if.sink),
    .name_o (name_if.source)
  );

  fsnp_name_checker checker_i (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .path_i     (path_if),
    .name_i     (name_if),
    .mismatch_o (fail_count),
    .pending_o  (names_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop: far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Name sink: random stalls per phase, plus the long hold-off when asked
  initial begin
    name_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      name_if.ready <= !hold_off && ($urandom_range(99) >= stall_pct);
    end
  end

  // Long receiver hold-off, counted here so the sender keeps offering bytes.
  // The parser keeps taking plain bytes, but the second terminator behind an
  // unread name must stall the input.
  initial begin
    wait (hold_go);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // One path byte transaction. Idle cycles are rolled before the byte is
  // offered; once offered, valid stays up until ready is seen at an edge.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      path_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    path_if.valid     <= 1'b1;
    path_if.path_byte <= b;
    do @(posedge clk_i); while (path_if.ready !== 1'b1);
    bytes_sent++;
  endtask

  task automatic send_text(input string s, input logic [7:0] term);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    send_byte(term);
  endtask

  function automatic logic [7:0] pick_alnum();
    case ($urandom_range(2))
      0:       return 8'($urandom_range(8'h61, 8'h7A));
      1:       return 8'($urandom_range(8'h41, 8'h5A));
      default: return 8'($urandom_range(8'h30, 8'h39));
    endcase
  endfunction

  function automatic logic [7:0] pick_reserved();
    case ($urandom_range(4))
      0:       return 8'h22;
      1:       return 8'($urandom_range(8'h2A, 8'h2D));
      2:       return 8'($urandom_range(8'h3A, 8'h3F));
      3:       return 8'($urandom_range(8'h5B, 8'h5D));
      default: return 8'($urandom_range(8'h7C, 8'h7E));
    endcase
  endfunction

  // A byte that neither ends a component nor is a dot; reserved ones are rare
  function automatic logic [7:0] pick_name_char();
    int r;
    r = $urandom_range(99);
    if (r < 60) return pick_alnum();
    if (r < 72) return 8'($urandom_range(8'h80, 8'hFF));
    if (r < 80) return 8'($urandom_range(8'h01, 8'h1F));
    if (r < 95) return 8'($urandom_range(8'h20, 8'h29));
    return pick_reserved();
  endfunction

  function automatic logic [7:0] pick_ext_char();
    int r;
    r = $urandom_range(99);
    if (r < 90) return pick_alnum();
    if (r < 94) return ChDot;
    return pick_name_char();
  endfunction

  // One component plus its terminator. Mostly well-formed 8.3 names with
  // random content; the rest are dot forms, empties, noise and long runs.
  task automatic send_random_component();
    int          roll;
    int          n;
    logic [7:0]  term;
    roll = $urandom_range(99);
    term = ($urandom_range(99) < 20) ? ChNul : ChSlash;
    if (roll < 7) begin
      // ".", "..", "..." and dotted junk like ".x"
      n = $urandom_range(1, 3);
      repeat (n) send_byte(ChDot);
      if ($urandom_range(99) < 30) begin
        n = $urandom_range(1, 3);
        repeat (n) send_byte(pick_name_char());
      end
    end else if (roll < 14) begin
      // raw noise, terminators included
      n = $urandom_range(1, 12);
      repeat (n) send_byte(8'($urandom_range(255)));
    end else if (roll < 15) begin
      // long run across the 255 saturation point
      n = $urandom_range(250, 270);
      repeat (n) send_byte(pick_name_char());
    end else if (roll < 20) begin
      // empty component: terminator only
    end else begin
      n = ($urandom_range(99) < 5) ? 0 : $urandom_range(1, 10);
      repeat (n) send_byte(pick_name_char());
      if ($urandom_range(99) < 70) begin
        send_byte(ChDot);
        n = $urandom_range(0, 4);
        repeat (n) send_byte(pick_ext_char());
      end
    end
    send_byte(term);
  endtask

  int idle_tbl[4]  = '{0, 70, 0, 29};
  int stall_tbl[4] = '{0, 0, 70, 29};

  initial begin
    path_if.valid     = 1'b0;
    path_if.path_byte = ChNul;
    rst_ni            = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty, dot, dot-dot, bad leading dot, a full name with a high
    // byte, ignored excess base/extension chars and case folding, reserved char
    send_text("", ChSlash);
    send_text(".", ChSlash);
    send_text("..", ChNul);
    send_text("...", ChSlash);
    send_text("\377bcDEfgh|.a1b.", ChNul);
    send_text("aB*", ChSlash);

    // Random phases: no idling, sender idle, receiver stalling, both
    for (int p = 0; p < 4; p++) begin
      idle_pct  = idle_tbl[p];
      stall_pct <= stall_tbl[p];
      while (bytes_sent < 28 + 370 * (p + 1)) send_random_component();
    end

    // Back-pressure phase: full-rate sender against a held-off receiver
    idle_pct  = 0;
    stall_pct <= 0;
    hold_go   <= 1'b1;
    while (bytes_sent < 28 + 370 * 4 + 250) send_random_component();

    // Drain: wait for every predicted name, then a few cycles for strays
    path_if.valid <= 1'b0;
    stall_pct     <= 0;
    @(posedge clk_i);
    while (names_pending != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/fsnp_pkg.sv
hdl/fsnp_intf.sv
hdl/fsnp_char_class.sv
hdl/fsnp_accum.sv
hdl/fat_short_name_parser_unit.sv
bench/fsnp_name_checker.sv
bench/fat_short_name_parser_unit_tb.sv
